// ===== hw/rtl/tts_pkg.sv =====
package tts_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_X    = 3'd0,
    CFG_CAM_Y    = 3'd1,
    CFG_ZOOM     = 3'd2,
    CFG_ROT_COS  = 3'd3,
    CFG_ROT_SIN  = 3'd4,
    CFG_SCREEN_W = 3'd5,
    CFG_SCREEN_H = 3'd6
  } cfg_reg_e;

  // Register reset values
  localparam logic signed [23:0] CAM_X_RST    = 24'sd0;
  localparam logic signed [23:0] CAM_Y_RST    = 24'sd0;
  localparam logic        [15:0] ZOOM_RST     = 16'd8192;
  localparam logic signed [15:0] ROT_COS_RST  = 16'sd16384;
  localparam logic signed [15:0] ROT_SIN_RST  = 16'sd0;
  localparam logic        [13:0] SCREEN_W_RST = 14'd1280;
  localparam logic        [13:0] SCREEN_H_RST = 14'd720;

  // Box edges are held in Q.36 over 61 bits
  localparam int unsigned EDGE_W    = 61;
  localparam int unsigned EDGE_FRAC = 36;
  localparam int unsigned PIX_W     = EDGE_W - EDGE_FRAC;
  localparam logic signed [EDGE_W-1:0] CEIL_BIAS = {{PIX_W{1'b0}}, {EDGE_FRAC{1'b1}}};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

endpackage

// ===== hw/rtl/tile_to_screen_scissor_rect.sv =====
// Each tile passes through register stages 0 to 5 before its result is offered on the output.
// Throughput: one tile per cycle; the six register stages advance independently, so a
// bubble closes up and a stalled output only holds the stages behind it once they fill.
// Reset (rst_ni low, asynchronous): all stage valid bits clear, the configuration
// registers take their power-on values (zoom 1.0, cos 1.0, sin 0, 1280 x 720 screen).
module tile_to_screen_scissor_rect (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [tts_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tts_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // tile input channel
  input  logic                               tile_valid_i,
  output logic                               tile_ready_o,
  input  logic signed [23:0]                 tile_x_i,
  input  logic signed [23:0]                 tile_y_i,
  input  logic signed [23:0]                 tile_width_i,
  input  logic signed [23:0]                 tile_height_i,
  input  logic [7:0]                         red_i,
  input  logic [7:0]                         green_i,
  input  logic [7:0]                         blue_i,
  // scissor rectangle output channel
  output logic                               rect_valid_o,
  input  logic                               rect_ready_i,
  output logic                               draw_o,
  output logic signed [15:0]                 rect_x_o,
  output logic signed [15:0]                 rect_y_o,
  output logic [15:0]                        rect_width_o,
  output logic [15:0]                        rect_height_o,
  output logic [7:0]                         red_out_o,
  output logic [7:0]                         green_out_o,
  output logic [7:0]                         blue_out_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipeline is
  // empty (the block itself does not enforce this), so every stage can read them live.
  // ---------------------------------------------------------------------------
  logic signed [23:0] cam_x_q, cam_y_q;
  logic        [15:0] zoom_q;
  logic signed [15:0] rot_cos_q, rot_sin_q;
  logic        [13:0] screen_w_q, screen_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q    <= tts_pkg::CAM_X_RST;
      cam_y_q    <= tts_pkg::CAM_Y_RST;
      zoom_q     <= tts_pkg::ZOOM_RST;
      rot_cos_q  <= tts_pkg::ROT_COS_RST;
      rot_sin_q  <= tts_pkg::ROT_SIN_RST;
      screen_w_q <= tts_pkg::SCREEN_W_RST;
      screen_h_q <= tts_pkg::SCREEN_H_RST;
    end else if (cfg_we_i) begin
      case (tts_pkg::cfg_reg_e'(cfg_idx_i))
        tts_pkg::CFG_CAM_X:    cam_x_q    <= $signed(cfg_wdata_i[23:0]);
        tts_pkg::CFG_CAM_Y:    cam_y_q    <= $signed(cfg_wdata_i[23:0]);
        tts_pkg::CFG_ZOOM:     zoom_q     <= cfg_wdata_i[15:0];
        tts_pkg::CFG_ROT_COS:  rot_cos_q  <= $signed(cfg_wdata_i[15:0]);
        tts_pkg::CFG_ROT_SIN:  rot_sin_q  <= $signed(cfg_wdata_i[15:0]);
        tts_pkg::CFG_SCREEN_W: screen_w_q <= cfg_wdata_i[13:0];
        tts_pkg::CFG_SCREEN_H: screen_h_q <= cfg_wdata_i[13:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valid bits and load enables. Stage 5 is the output register.
  // A stage loads when it is empty or when the stage after it loads.
  // ---------------------------------------------------------------------------
  logic [5:0] v_q;
  logic [5:0] ld;

  always_comb begin
    ld[5] = !v_q[5] || rect_ready_i;
    for (int k = 4; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  assign tile_ready_o = ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= tile_valid_i;
      for (int k = 1; k < 6; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Colour travels alongside the arithmetic
  tts_pkg::colour_t col_q [6];

  always_ff @(posedge clk_i) begin
    if (ld[0]) col_q[0] <= '{red: red_i, green: green_i, blue: blue_i};
    for (int k = 1; k < 6; k++) begin
      if (ld[k]) col_q[k] <= col_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: offset from camera (Q.8)
  // ---------------------------------------------------------------------------
  logic signed [24:0] dx_q, dy_q;
  logic signed [23:0] tw_q, th_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      dx_q <= 25'(tile_x_i) - 25'(cam_x_q);
      dy_q <= 25'(tile_y_i) - 25'(cam_y_q);
      tw_q <= tile_width_i;
      th_q <= tile_height_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: scale by zoom (Q.21)
  // ---------------------------------------------------------------------------
  logic signed [16:0] zoom_s;
  logic signed [41:0] sx_d, sy_d, sx_q, sy_q;
  logic signed [40:0] sw_d, sh_d, sw_q, sh_q;

  assign zoom_s = $signed({1'b0, zoom_q});

  always_comb begin
    sx_d = dx_q * zoom_s;
    sy_d = dy_q * zoom_s;
    sw_d = tw_q * zoom_s;
    sh_d = th_q * zoom_s;
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      sw_q <= sw_d;
      sh_q <= sh_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: rotation and half-extent products (Q.35 and Q.36)
  // ---------------------------------------------------------------------------
  logic signed [16:0] abs_cos, abs_sin;
  logic signed [57:0] p_d [8];
  logic signed [57:0] p_q [8];
  logic               size_ok_q2;

  always_comb begin
    abs_cos = rot_cos_q[15] ? -17'(rot_cos_q) : 17'(rot_cos_q);
    abs_sin = rot_sin_q[15] ? -17'(rot_sin_q) : 17'(rot_sin_q);
    p_d[0] = sx_q * rot_cos_q;
    p_d[1] = sy_q * rot_sin_q;
    p_d[2] = sx_q * rot_sin_q;
    p_d[3] = sy_q * rot_cos_q;
    // half size in Q.22 is the scaled size taken as is
    p_d[4] = sw_q * abs_cos;
    p_d[5] = sh_q * abs_sin;
    p_d[6] = sw_q * abs_sin;
    p_d[7] = sh_q * abs_cos;
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      p_q        <= p_d;
      size_ok_q2 <= (sw_q > 41'sd0) && (sh_q > 41'sd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: box centre on screen and rotated half extents (Q.36)
  // ---------------------------------------------------------------------------
  logic signed [58:0]                 rx, ry;
  logic signed [tts_pkg::EDGE_W-1:0]  cx_d, cy_d, hw_d, hh_d;
  logic signed [tts_pkg::EDGE_W-1:0]  cx_q, cy_q, hw_q, hh_q;
  logic                               size_ok_q3;

  always_comb begin
    rx   = p_q[0] - p_q[1];
    ry   = p_q[2] + p_q[3];
    // screen / 2 in Q.36 is the size shifted left by 35
    cx_d = $signed({12'b0, screen_w_q, 35'b0}) + $signed({rx[58], rx, 1'b0});
    cy_d = $signed({12'b0, screen_h_q, 35'b0}) + $signed({ry[58], ry, 1'b0});
    hw_d = p_q[4] + p_q[5];
    hh_d = p_q[6] + p_q[7];
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      cx_q       <= cx_d;
      cy_q       <= cy_d;
      hw_q       <= hw_d;
      hh_q       <= hh_d;
      size_ok_q3 <= size_ok_q2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: floor the low edges, ceil the high edges to whole pixels
  // ---------------------------------------------------------------------------
  logic signed [tts_pkg::EDGE_W-1:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [tts_pkg::PIX_W-1:0]  left_q, bottom_q, right_q, top_q;
  logic                              size_ok_q4;

  always_comb begin
    lo_x = cx_q - hw_q;
    lo_y = cy_q - hh_q;
    hi_x = cx_q + hw_q + tts_pkg::CEIL_BIAS;
    hi_y = cy_q + hh_q + tts_pkg::CEIL_BIAS;
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      left_q     <= $signed(lo_x[tts_pkg::EDGE_W-1:tts_pkg::EDGE_FRAC]);
      bottom_q   <= $signed(lo_y[tts_pkg::EDGE_W-1:tts_pkg::EDGE_FRAC]);
      right_q    <= $signed(hi_x[tts_pkg::EDGE_W-1:tts_pkg::EDGE_FRAC]);
      top_q      <= $signed(hi_y[tts_pkg::EDGE_W-1:tts_pkg::EDGE_FRAC]);
      size_ok_q4 <= size_ok_q3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5 (output register): extent, skip decision and saturation
  // ---------------------------------------------------------------------------
  logic signed [tts_pkg::PIX_W:0] w_full, h_full;
  logic                           draw_d;
  logic signed [15:0]             rect_x_d, rect_y_d;
  logic        [15:0]             rect_w_d, rect_h_d;

  always_comb begin
    w_full = right_q - left_q;
    h_full = top_q - bottom_q;
    draw_d = size_ok_q4 && (w_full > 26'sd0) && (h_full > 26'sd0);
    rect_x_d = '0;
    rect_y_d = '0;
    rect_w_d = '0;
    rect_h_d = '0;
    if (draw_d) begin
      if (left_q > 25'sd32767)        rect_x_d = 16'sh7FFF;
      else if (left_q < -25'sd32768)  rect_x_d = -16'sh8000;
      else                            rect_x_d = left_q[15:0];
      if (bottom_q > 25'sd32767)       rect_y_d = 16'sh7FFF;
      else if (bottom_q < -25'sd32768) rect_y_d = -16'sh8000;
      else                             rect_y_d = bottom_q[15:0];
      rect_w_d = (w_full > 26'sd65535) ? 16'hFFFF : w_full[15:0];
      rect_h_d = (h_full > 26'sd65535) ? 16'hFFFF : h_full[15:0];
    end
  end

  logic               draw_q;
  logic signed [15:0] rect_x_q, rect_y_q;
  logic        [15:0] rect_w_q, rect_h_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      draw_q   <= draw_d;
      rect_x_q <= rect_x_d;
      rect_y_q <= rect_y_d;
      rect_w_q <= rect_w_d;
      rect_h_q <= rect_h_d;
    end
  end

  assign rect_valid_o  = v_q[5];
  assign draw_o        = draw_q;
  assign rect_x_o      = rect_x_q;
  assign rect_y_o      = rect_y_q;
  assign rect_width_o  = rect_w_q;
  assign rect_height_o = rect_h_q;
  assign red_out_o     = col_q[5].red;
  assign green_out_o   = col_q[5].green;
  assign blue_out_o    = col_q[5].blue;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_draw_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o && draw_o |-> rect_width_o != 16'd0 && rect_height_o != 16'd0)
    else $error("drawn rectangle with zero extent");

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o && !draw_o |->
      rect_x_o == 16'sd0 && rect_y_o == 16'sd0 &&
      rect_width_o == 16'd0 && rect_height_o == 16'd0)
    else $error("skipped tile carries a non-zero rectangle");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !rect_ready_i |-> !tile_ready_o)
    else $error("input taken while the whole pipeline is stalled");

  a_hold_stage0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !ld[1] |=> v_q[0])
    else $error("stalled item lost from the first stage");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tile_valid_i && tile_ready_o |=> v_q[0])
    else $error("transferred tile did not enter the pipeline");

endmodule
